// File: rtl/core/lpfcs_pkg.sv
// ============================================================================
// lpfcs_pkg
// Shared types, command codes and defaults for the LCD page frame streamer.
// ============================================================================
package lpfcs_pkg;

    // Geometry defaults
    localparam int COLUMNS_DEFAULT = 132;
    localparam int PAGES_DEFAULT   = 8;

    // Depth of the job queue between front and back
    localparam int JOBQ_DEPTH = 2;

    // Register map (index = paddr / 4)
    localparam int ADDR_W = 5;
    localparam logic [2:0] REG_PAGE_OFFSET = 3'd0;
    localparam logic [2:0] REG_CONTRAST    = 3'd1;
    localparam logic [2:0] REG_BIAS        = 3'd2;
    localparam logic [2:0] REG_REG_RATIO   = 3'd3;
    localparam logic [2:0] REG_INVERSE     = 3'd4;

    // Register reset values
    localparam logic [2:0] PAGE_OFFSET_RST = 3'd4;
    localparam logic [5:0] CONTRAST_RST    = 6'd28;
    localparam logic       BIAS_RST        = 1'b0;
    localparam logic [2:0] REG_RATIO_RST   = 3'd7;
    localparam logic       INVERSE_RST     = 1'b0;

    // Controller command bytes
    localparam logic [7:0] CMD_RESET       = 8'hE2;
    localparam logic [7:0] CMD_START_LINE  = 8'h40;
    localparam logic [7:0] CMD_ADC_NORMAL  = 8'hA0;
    localparam logic [7:0] CMD_COM_REVERSE = 8'hC8;
    localparam logic [7:0] CMD_BIAS        = 8'hA2;
    localparam logic [7:0] CMD_POWER_ALL   = 8'h2F;
    localparam logic [7:0] CMD_BOOSTER     = 8'hF8;
    localparam logic [7:0] CMD_BOOST_4X    = 8'h00;
    localparam logic [7:0] CMD_REG_RATIO   = 8'h20;
    localparam logic [7:0] CMD_VOLUME      = 8'h81;
    localparam logic [7:0] CMD_DISP_MODE   = 8'hA6;
    localparam logic [7:0] CMD_DISP_ON     = 8'hAF;
    localparam logic [7:0] CMD_PAGE_ADDR   = 8'hB0;
    localparam logic [7:0] CMD_COL_HIGH    = 8'h10;
    localparam logic [7:0] CMD_COL_LOW     = 8'h00;

    // Byte counts of the init and head jobs, minus one
    localparam logic [3:0] INIT_LAST_IDX = 4'd11;
    localparam logic [3:0] HEAD_LAST_IDX = 4'd3;

    // Job kinds
    localparam logic [1:0] JOB_INIT  = 2'd0;
    localparam logic [1:0] JOB_HEAD  = 2'd1;
    localparam logic [1:0] JOB_PIXEL = 2'd2;

    typedef struct packed {
        logic [1:0] kind;
        logic [2:0] page;
        logic [7:0] pixel;
    } job_t;

    typedef struct packed {
        logic [2:0] page_offset;
        logic [5:0] contrast_level;
        logic       bias_select;
        logic [2:0] regulation_ratio;
        logic       inverse_display;
    } cfg_t;

endpackage

// File: rtl/core/lcd_page_frame_command_streamer.sv
// ============================================================================
// lcd_page_frame_command_streamer
// Byte streamer for a page-organised LCD controller: init sequence and
// frame-buffer bytes with page and column commands, each with an A0 flag.
// ============================================================================
// Usage:
//   Requests enter through push/full (req_type, pixel_byte); a request is
//   taken on a clock edge with push high and full low. Output beats leave
//   through empty/pop (out_byte, is_data, last_of_run); last_of_run marks
//   the final beat of each request.
//   An init request yields 12 command beats and rewinds to page 0,
//   column 0. A pixel request yields one data beat, or four beats (page
//   address, column high, column low, data) at column 0.
//   The first beat of a request passes through the job queue and then the
//   output register. The back end emits one beat per cycle while the
//   receiver pops; the two-entry job queue lets the front take new
//   requests while the back end works.
//   When the receiver holds pop low, the output beat holds, the job queue
//   fills and full rises; nothing is dropped.
//   Reset clears the position, the queue and the output; the registers
//   return to their defaults. The user must write registers over the
//   APB port only while the block is idle, which it does not enforce.
// ============================================================================
module lcd_page_frame_command_streamer
#(
    parameter int COLUMNS = lpfcs_pkg::COLUMNS_DEFAULT,
    parameter int PAGES   = lpfcs_pkg::PAGES_DEFAULT
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic                         req_type,
    input  logic [7:0]                   pixel_byte,
    output logic                         empty,
    input  logic                         pop,
    output logic [7:0]                   out_byte,
    output logic                         is_data,
    output logic                         last_of_run,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [lpfcs_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    lpfcs_pkg::cfg_t cfg;
    lpfcs_pkg::job_t front_job;
    lpfcs_pkg::job_t back_job;
    logic            accept;
    logic            job_empty;
    logic            job_pop;

    assign accept = push && !full;

    lpfcs_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    lpfcs_front
    #(
        .COLUMNS (COLUMNS),
        .PAGES   (PAGES)
    )
    u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .req_type    (req_type),
        .pixel_byte  (pixel_byte),
        .page_offset (cfg.page_offset),
        .job         (front_job)
    );

    lpfcs_fifo
    #(
        .DEPTH (lpfcs_pkg::JOBQ_DEPTH)
    )
    u_jobq
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (front_job),
        .full  (full),
        .pop   (job_pop),
        .rdata (back_job),
        .empty (job_empty)
    );

    lpfcs_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .job         (back_job),
        .job_empty   (job_empty),
        .job_pop     (job_pop),
        .out_byte    (out_byte),
        .is_data     (is_data),
        .last_of_run (last_of_run),
        .empty       (empty),
        .pop         (pop)
    );

endmodule

// File: rtl/core/lpfcs_regs.sv
// ============================================================================
// lpfcs_regs
// APB-style configuration registers; always ready, reads return the value.
// ============================================================================
module lpfcs_regs
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [lpfcs_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    output lpfcs_pkg::cfg_t              cfg
);

    lpfcs_pkg::cfg_t cfg_reg;
    lpfcs_pkg::cfg_t cfg_next;
    logic [2:0]      reg_idx;
    logic            wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;
    assign cfg     = cfg_reg;

    // Decode write beat
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                lpfcs_pkg::REG_PAGE_OFFSET: cfg_next.page_offset      = pwdata[2:0];
                lpfcs_pkg::REG_CONTRAST:    cfg_next.contrast_level   = pwdata[5:0];
                lpfcs_pkg::REG_BIAS:        cfg_next.bias_select      = pwdata[0];
                lpfcs_pkg::REG_REG_RATIO:   cfg_next.regulation_ratio = pwdata[2:0];
                lpfcs_pkg::REG_INVERSE:     cfg_next.inverse_display  = pwdata[0];
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.page_offset      <= lpfcs_pkg::PAGE_OFFSET_RST;
            cfg_reg.contrast_level   <= lpfcs_pkg::CONTRAST_RST;
            cfg_reg.bias_select      <= lpfcs_pkg::BIAS_RST;
            cfg_reg.regulation_ratio <= lpfcs_pkg::REG_RATIO_RST;
            cfg_reg.inverse_display  <= lpfcs_pkg::INVERSE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Read mux
    always_comb
    begin
        unique case (reg_idx)
            lpfcs_pkg::REG_PAGE_OFFSET: prdata = {29'd0, cfg_reg.page_offset};
            lpfcs_pkg::REG_CONTRAST:    prdata = {26'd0, cfg_reg.contrast_level};
            lpfcs_pkg::REG_BIAS:        prdata = {31'd0, cfg_reg.bias_select};
            lpfcs_pkg::REG_REG_RATIO:   prdata = {29'd0, cfg_reg.regulation_ratio};
            lpfcs_pkg::REG_INVERSE:     prdata = {31'd0, cfg_reg.inverse_display};
            default:                    prdata = 32'd0;
        endcase
    end

endmodule

// File: rtl/core/lpfcs_front.sv
// ============================================================================
// lpfcs_front
// Accepts requests, tracks the frame position and classifies each request
// into a job for the back end.
// ============================================================================
module lpfcs_front
#(
    parameter int COLUMNS = lpfcs_pkg::COLUMNS_DEFAULT,
    parameter int PAGES   = lpfcs_pkg::PAGES_DEFAULT
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic              req_type,
    input  logic [7:0]        pixel_byte,
    input  logic [2:0]        page_offset,
    output lpfcs_pkg::job_t   job
);

    localparam logic [3:0] PAGES_W4   = 4'(PAGES);
    localparam logic [8:0] COLUMNS_W9 = 9'(COLUMNS);

    logic [7:0] column_count_reg;
    logic [7:0] column_count_next;
    logic [2:0] page_count_reg;
    logic [2:0] page_count_next;

    logic [2:0] page_cur;
    logic [3:0] offset_mod;
    logic [3:0] page_sum;
    logic [3:0] disp_page;
    logic [8:0] col_inc;
    logic [3:0] page_inc;

    // Reduce the offset below PAGES by repeated subtraction
    always_comb
    begin
        offset_mod = {1'b0, page_offset};
        for (int i = 0; i < 7; i++)
        begin
            if (offset_mod >= PAGES_W4)
                offset_mod = offset_mod - PAGES_W4;
        end
    end

    // Display page: sum stays below twice PAGES, so one subtract wraps it
    assign page_cur  = ({1'b0, page_count_reg} >= PAGES_W4) ? 3'd0 : page_count_reg;
    assign page_sum  = {1'b0, page_cur} + offset_mod;
    assign disp_page = (page_sum >= PAGES_W4) ? (page_sum - PAGES_W4) : page_sum;

    // Classify the request
    always_comb
    begin
        job.pixel = pixel_byte;
        job.page  = disp_page[2:0];
        if (!req_type)
            job.kind = lpfcs_pkg::JOB_INIT;
        else if (column_count_reg == 8'd0)
            job.kind = lpfcs_pkg::JOB_HEAD;
        else
            job.kind = lpfcs_pkg::JOB_PIXEL;
    end

    // Advance the frame position
    assign col_inc  = {1'b0, column_count_reg} + 9'd1;
    assign page_inc = {1'b0, page_cur} + 4'd1;

    always_comb
    begin
        column_count_next = column_count_reg;
        page_count_next   = page_count_reg;
        if (accept)
        begin
            if (!req_type)
            begin
                column_count_next = 8'd0;
                page_count_next   = 3'd0;
            end
            else if (col_inc >= COLUMNS_W9)
            begin
                column_count_next = 8'd0;
                page_count_next   = (page_inc >= PAGES_W4) ? 3'd0 : page_inc[2:0];
            end
            else
            begin
                column_count_next = col_inc[7:0];
                page_count_next   = page_cur;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_count_reg <= 8'd0;
            page_count_reg   <= 3'd0;
        end
        else
        begin
            column_count_reg <= column_count_next;
            page_count_reg   <= page_count_next;
        end
    end

endmodule

// File: rtl/core/lpfcs_fifo.sv
// ============================================================================
// lpfcs_fifo
// Short job queue between the front and back ends.
// ============================================================================
module lpfcs_fifo
#(
    parameter int DEPTH = lpfcs_pkg::JOBQ_DEPTH
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  lpfcs_pkg::job_t   wdata,
    output logic              full,
    input  logic              pop,
    output lpfcs_pkg::job_t   rdata,
    output logic              empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
    localparam logic [PTR_W-1:0] LAST_P  = PTR_W'(DEPTH - 1);

    lpfcs_pkg::job_t  mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == DEPTH_C);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem[rd_ptr_reg];

    // Store pushed job
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= wdata;
    end

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == LAST_P) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == LAST_P) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: rtl/core/lpfcs_back.sv
// ============================================================================
// lpfcs_back
// Expands each job into its byte sequence in an output register that
// the receiver drains, one byte per cycle while the receiver pops.
// ============================================================================
module lpfcs_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  lpfcs_pkg::cfg_t   cfg,
    input  lpfcs_pkg::job_t   job,
    input  logic              job_empty,
    output logic              job_pop,
    output logic [7:0]        out_byte,
    output logic              is_data,
    output logic              last_of_run,
    output logic              empty,
    input  logic              pop
);

    logic [3:0] idx_reg;
    logic [3:0] idx_next;
    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       data_reg;
    logic       last_reg;

    logic [7:0] sel_byte;
    logic       sel_data;
    logic       sel_last;
    logic [7:0] init_byte;
    logic [7:0] head_byte;
    logic       slot_free;
    logic       load;

    // Init sequence byte
    always_comb
    begin
        unique case (idx_reg)
            4'd0:    init_byte = lpfcs_pkg::CMD_RESET;
            4'd1:    init_byte = lpfcs_pkg::CMD_START_LINE;
            4'd2:    init_byte = lpfcs_pkg::CMD_ADC_NORMAL;
            4'd3:    init_byte = lpfcs_pkg::CMD_COM_REVERSE;
            4'd4:    init_byte = lpfcs_pkg::CMD_BIAS | {7'd0, cfg.bias_select};
            4'd5:    init_byte = lpfcs_pkg::CMD_POWER_ALL;
            4'd6:    init_byte = lpfcs_pkg::CMD_BOOSTER;
            4'd7:    init_byte = lpfcs_pkg::CMD_REG_RATIO | {5'd0, cfg.regulation_ratio};
            4'd8:    init_byte = lpfcs_pkg::CMD_VOLUME;
            4'd9:    init_byte = {2'd0, cfg.contrast_level};
            4'd10:   init_byte = lpfcs_pkg::CMD_DISP_MODE | {7'd0, cfg.inverse_display};
            default: init_byte = lpfcs_pkg::CMD_DISP_ON;
        endcase
    end

    // Page start header, then the data byte
    always_comb
    begin
        unique case (idx_reg[1:0])
            2'd0:    head_byte = lpfcs_pkg::CMD_PAGE_ADDR | {5'd0, job.page};
            2'd1:    head_byte = lpfcs_pkg::CMD_COL_HIGH;
            2'd2:    head_byte = lpfcs_pkg::CMD_COL_LOW;
            default: head_byte = job.pixel;
        endcase
    end

    // Select byte by job kind
    always_comb
    begin
        unique case (job.kind)
            lpfcs_pkg::JOB_INIT:
            begin
                sel_byte = init_byte;
                sel_last = (idx_reg == lpfcs_pkg::INIT_LAST_IDX);
                sel_data = 1'b0;
            end
            lpfcs_pkg::JOB_HEAD:
            begin
                sel_byte = head_byte;
                sel_last = (idx_reg == lpfcs_pkg::HEAD_LAST_IDX);
                sel_data = sel_last;
            end
            default:
            begin
                sel_byte = job.pixel;
                sel_last = 1'b1;
                sel_data = 1'b1;
            end
        endcase
    end

    assign slot_free = !valid_reg || pop;
    assign load      = slot_free && !job_empty;
    assign job_pop   = load && sel_last;

    // Step through the job and hold the output slot
    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (slot_free)
            valid_next = !job_empty;
        if (load)
            idx_next = sel_last ? 4'd0 : idx_reg + 4'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 4'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    // Capture the output beat
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= sel_byte;
            data_reg <= sel_data;
            last_reg <= sel_last;
        end
    end

    assign out_byte    = byte_reg;
    assign is_data     = data_reg;
    assign last_of_run = last_reg;
    assign empty       = !valid_reg;

endmodule
